// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock, switched off while reset is low
`define RSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion sampled on the rising clock, active during reset as well
`define RSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rsi_pkg.sv -----
// ---------------------------------------------------------------------------
// rsi_pkg
// Constants, types and state encodings shared by the RSI core modules.
// ---------------------------------------------------------------------------
package rsi_pkg;

    // Sizing
    localparam int MAX_PERIOD  = 64;
    localparam int PRICE_BITS  = 32;
    localparam int PTR_W       = $clog2(MAX_PERIOD);
    localparam int PERIOD_W    = 7;
    localparam int SEEN_MIN_W  = $clog2(MAX_PERIOD + 2);
    localparam int CNT_W       = (PERIOD_W > SEEN_MIN_W) ? PERIOD_W : SEEN_MIN_W;
    localparam int DIFF_W      = PRICE_BITS + 1;
    localparam int SUM_W       = PRICE_BITS + 11;
    localparam int TOT_W       = SUM_W + 1;
    localparam int REM_W       = SUM_W + 2;

    // Ratio scaling: 100 percent in units of 1/256 percent
    localparam int SCALE_W     = 15;
    localparam logic [SCALE_W-1:0] SCALE = 15'd25600;
    localparam int Q_W         = SCALE_W + 1;
    localparam int BIT_W       = $clog2(SCALE_W);
    localparam int RSI_W       = 15;

    // Input queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_IDX_W   = CFG_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = '0;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 7'd14;

    // Queued input beat
    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic                  restart;
    } rsi_item_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] gain;
        logic [TOT_W-1:0] total;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [RSI_W-1:0] ratio;
    } div_rsp_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        EN_IDLE,
        EN_READ,
        EN_ADD,
        EN_TOTAL,
        EN_DIV,
        EN_OUT
    } eng_state_t;

    // Divider sequencer
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_SHIFT,
        DV_ADD,
        DV_SUB
    } div_state_t;

endpackage

// ----- sv/rsi_queue.sv -----
// ---------------------------------------------------------------------------
// rsi_queue
// Two-entry input queue between the stream slave side and the back end.
// ---------------------------------------------------------------------------
module rsi_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsi_pkg::rsi_item_t in_item,
    output logic               out_valid,
    input  logic               out_pop,
    output rsi_pkg::rsi_item_t out_item
);
    import rsi_pkg::*;

    rsi_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- sv/rsi_ram.sv -----
// ---------------------------------------------------------------------------
// rsi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rsi_divider.sv -----
// ---------------------------------------------------------------------------
// rsi_divider
// Bit-serial scaled ratio: floor(25600 * gain / total), one quotient bit
// per shift step plus an add and a subtract step for each set scale bit.
// ---------------------------------------------------------------------------
module rsi_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rsi_pkg::div_req_t req,
    output rsi_pkg::div_rsp_t rsp
);
    import rsi_pkg::*;

    div_state_t       state_reg, state_next;
    logic [REM_W-1:0] r_reg, r_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [BIT_W-1:0] b_reg, b_next;
    logic [SUM_W-1:0] g_reg, g_next;
    logic [TOT_W-1:0] t_reg, t_next;
    logic             done_reg, done_next;

    logic [REM_W-1:0] cs_in;
    logic [REM_W:0]   cs_diff;
    logic             cs_ge;
    logic [Q_W-1:0]   q_base;
    logic             scale_bit;

    // Shared compare-and-subtract against the total
    assign cs_in     = (state_reg == DV_SHIFT) ? {r_reg[REM_W-2:0], 1'b0} : r_reg;
    assign cs_diff   = {1'b0, cs_in} - (REM_W + 1)'(t_reg);
    assign cs_ge     = !cs_diff[REM_W];
    assign q_base    = (state_reg == DV_SHIFT) ? {q_reg[Q_W-2:0], 1'b0} : q_reg;
    assign scale_bit = SCALE[b_reg];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DV_SHIFT;
                end
            end
            DV_SHIFT:
            begin
                if (scale_bit)
                begin
                    state_next = DV_ADD;
                end
                else if (b_reg == '0)
                begin
                    state_next = DV_IDLE;
                end
            end
            DV_ADD:
            begin
                state_next = DV_SUB;
            end
            DV_SUB:
            begin
                state_next = (b_reg == '0) ? DV_IDLE : DV_SHIFT;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    // Datapath updates
    always_comb
    begin
        r_next    = r_reg;
        q_next    = q_reg;
        b_next    = b_reg;
        g_next    = g_reg;
        t_next    = t_reg;
        done_next = 1'b0;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    g_next = req.gain;
                    t_next = req.total;
                    r_next = '0;
                    q_next = '0;
                    b_next = BIT_W'(SCALE_W - 1);
                end
            end
            DV_SHIFT:
            begin
                r_next = cs_ge ? cs_diff[REM_W-1:0] : cs_in;
                q_next = q_base + Q_W'(cs_ge);
                if (!scale_bit)
                begin
                    if (b_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        b_next = b_reg - 1'b1;
                    end
                end
            end
            DV_ADD:
            begin
                r_next = r_reg + REM_W'(g_reg);
            end
            DV_SUB:
            begin
                r_next = cs_ge ? cs_diff[REM_W-1:0] : cs_in;
                q_next = q_base + Q_W'(cs_ge);
                if (b_reg == '0)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    b_next = b_reg - 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        q_reg <= q_next;
        b_reg <= b_next;
        g_reg <= g_next;
        t_reg <= t_next;
    end

    // Result with saturation at full scale
    assign rsp.done  = done_reg;
    assign rsp.ratio = (q_reg > Q_W'(SCALE)) ? RSI_W'(SCALE) : q_reg[RSI_W-1:0];

endmodule

// ----- sv/rsi_engine.sv -----
// ---------------------------------------------------------------------------
// rsi_engine
// Back end: difference ring, gain and loss sums, result sequencing and the
// output register of the stream master side.
// ---------------------------------------------------------------------------
module rsi_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rsi_pkg::PERIOD_W-1:0]  period,
    input  logic                          item_valid,
    output logic                          item_pop,
    input  rsi_pkg::rsi_item_t            item,
    output rsi_pkg::div_req_t             div_req,
    input  rsi_pkg::div_rsp_t             div_rsp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rsi_pkg::RSI_W-1:0]     out_rsi,
    output logic                          out_flat
);
    import rsi_pkg::*;

    eng_state_t            state_reg, state_next;
    logic [SUM_W-1:0]      gain_reg, gain_next;
    logic [SUM_W-1:0]      loss_reg, loss_next;
    logic [PRICE_BITS-1:0] last_reg, last_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [PRICE_BITS-1:0] diff_reg, diff_next;
    logic                  neg_reg, neg_next;
    logic [RSI_W-1:0]      res_rsi_reg, res_rsi_next;
    logic                  res_flat_reg, res_flat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RSI_W-1:0]      out_rsi_reg, out_rsi_next;
    logic                  out_flat_reg, out_flat_next;

    logic [CNT_W-1:0]      per_ext, eff_p, p_plus1, seen_upd, ptr_inc;
    logic                  series_start;
    logic [TOT_W-1:0]      total_sum;
    logic                  ram_we;
    logic [DIFF_W-1:0]     ram_rdata;

    // Effective period: zero acts as one, clamp at ring depth
    assign per_ext = CNT_W'(period);
    assign eff_p   = (per_ext == '0) ? CNT_W'(1)
                   : (per_ext > CNT_W'(MAX_PERIOD)) ? CNT_W'(MAX_PERIOD) : per_ext;
    assign p_plus1 = eff_p + CNT_W'(1);

    assign series_start = item.restart || (seen_reg == '0);
    assign seen_upd     = (seen_reg < p_plus1) ? seen_reg + CNT_W'(1) : p_plus1;
    assign ptr_inc      = CNT_W'(ptr_reg) + CNT_W'(1);
    assign total_sum    = TOT_W'(gain_reg) + TOT_W'(loss_reg);
    assign ram_we       = (state_reg == EN_ADD);

    // Difference ring
    rsi_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata ({neg_reg, diff_reg}),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EN_IDLE:
            begin
                if (item_valid && !series_start)
                begin
                    state_next = EN_READ;
                end
            end
            EN_READ:
            begin
                state_next = EN_ADD;
            end
            EN_ADD:
            begin
                state_next = (seen_upd == p_plus1) ? EN_TOTAL : EN_IDLE;
            end
            EN_TOTAL:
            begin
                state_next = (total_sum == '0) ? EN_OUT : EN_DIV;
            end
            EN_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = EN_OUT;
                end
            end
            EN_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = EN_IDLE;
                end
            end
            default:
            begin
                state_next = EN_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        item_pop       = 1'b0;
        div_req.start  = 1'b0;
        div_req.gain   = gain_reg;
        div_req.total  = total_sum;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        last_next      = last_reg;
        seen_next      = seen_reg;
        ptr_next       = ptr_reg;
        price_next     = price_reg;
        diff_next      = diff_reg;
        neg_next       = neg_reg;
        res_rsi_next   = res_rsi_reg;
        res_flat_next  = res_flat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rsi_next   = out_rsi_reg;
        out_flat_next  = out_flat_reg;
        unique case (state_reg)
            EN_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (series_start)
                    begin
                        gain_next = '0;
                        loss_next = '0;
                        seen_next = CNT_W'(1);
                        ptr_next  = '0;
                        last_next = item.price;
                    end
                    else
                    begin
                        price_next = item.price;
                    end
                end
            end
            EN_READ:
            begin
                // Drop the oldest difference once the window is full
                if (seen_reg > eff_p)
                begin
                    if (ram_rdata[DIFF_W-1])
                    begin
                        loss_next = loss_reg - SUM_W'(ram_rdata[PRICE_BITS-1:0]);
                    end
                    else
                    begin
                        gain_next = gain_reg - SUM_W'(ram_rdata[PRICE_BITS-1:0]);
                    end
                end
                // Sign and magnitude of the new difference
                if (price_reg >= last_reg)
                begin
                    diff_next = price_reg - last_reg;
                    neg_next  = 1'b0;
                end
                else
                begin
                    diff_next = last_reg - price_reg;
                    neg_next  = 1'b1;
                end
            end
            EN_ADD:
            begin
                if (neg_reg)
                begin
                    loss_next = loss_reg + SUM_W'(diff_reg);
                end
                else
                begin
                    gain_next = gain_reg + SUM_W'(diff_reg);
                end
                last_next = price_reg;
                ptr_next  = (ptr_inc >= eff_p) ? '0 : ptr_inc[PTR_W-1:0];
                seen_next = seen_upd;
            end
            EN_TOTAL:
            begin
                if (total_sum == '0)
                begin
                    res_rsi_next  = '0;
                    res_flat_next = 1'b1;
                end
                else
                begin
                    div_req.start = 1'b1;
                end
            end
            EN_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_rsi_next  = div_rsp.ratio;
                    res_flat_next = 1'b0;
                end
            end
            EN_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rsi_next   = res_rsi_reg;
                    out_flat_next  = res_flat_reg;
                end
            end
            default:
            begin
                item_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EN_IDLE;
            gain_reg      <= '0;
            loss_reg      <= '0;
            last_reg      <= '0;
            seen_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            loss_reg      <= loss_next;
            last_reg      <= last_next;
            seen_reg      <= seen_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        diff_reg     <= diff_next;
        neg_reg      <= neg_next;
        res_rsi_reg  <= res_rsi_next;
        res_flat_reg <= res_flat_next;
        out_rsi_reg  <= out_rsi_next;
        out_flat_reg <= out_flat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rsi   = out_rsi_reg;
    assign out_flat  = out_flat_reg;

endmodule

// ----- sv/relative_strength_index_core.sv -----
// ---------------------------------------------------------------------------
// relative_strength_index_core
// Simple-moving-average RSI over a window of price differences.
// ---------------------------------------------------------------------------
// One price beat in, at most one RSI beat out. A two-entry input queue takes
// beats while the back end works, so the slave side keeps accepting, until
// both entries are full, while a finished result waits on the master side. A
// restart beat, or a warm-up beat before the window holds period differences,
// gives no result. A beat that gives a result goes through the ring read and
// sum update, then the bit-serial divider, which spends 15 shift steps plus
// an add and a subtract step for each of the three set bits of 25600 and
// then flags done from a register, and last the load of the output register.
// A flat window skips the divider. The divider sets the sustained rate. Write
// period only while idle, and follow a change with a restart beat.
module relative_strength_index_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // Stream slave: tdata = price[31:0]; tuser = restart[0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rsi_pkg::PRICE_BITS-1:0] s_tdata,
    input  logic [0:0]                     s_tuser,
    // Stream master: tdata = rsi[14:0], zero[15]; tuser = flat[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,
    output logic [0:0]                     m_tuser,
    // Configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rsi_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rsi_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rsi_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import rsi_pkg::*;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                cfg_wr;
    rsi_item_t           in_item, q_item;
    logic                q_valid, q_pop;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic [RSI_W-1:0]    out_rsi;
    logic                out_flat;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        period_next = period_reg;
        if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_PERIOD))
        begin
            period_next = pwdata[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else
        begin
            period_reg <= period_next;
        end
    end

    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_PERIOD) ? CFG_DATA_W'(period_reg) : '0;

    // Front end queue
    assign in_item.price   = s_tdata;
    assign in_item.restart = s_tuser[0];

    rsi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    // Back end
    rsi_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .period     (period_reg),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .item       (q_item),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rsi    (out_rsi),
        .out_flat   (out_flat)
    );

    rsi_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign m_tdata = {1'b0, out_rsi};
    assign m_tuser = out_flat;

endmodule

// ----- sv/rsi_checker.sv -----
// ---------------------------------------------------------------------------
// rsi_checker
// Port-level checks on the RSI result stream, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic        out_stall;
    logic [17:0] out_beat;
    logic        flat_beat;

    assign out_stall = m_tvalid && !m_tready;
    assign out_beat  = {m_tvalid, m_tuser, m_tdata};
    assign flat_beat = m_tvalid && m_tuser[0];

    // Stalled result beat holds
    `RSI_ASSERT(a_out_hold, clk, rst_n, out_stall |=> $stable(out_beat), "stalled beat changed")

    // Index never passes full scale
    `RSI_ASSERT(a_out_range, clk, rst_n, m_tvalid |-> (m_tdata <= 16'd25600), "rsi out of range")

    // Flat window reports zero
    `RSI_ASSERT(a_flat_zero, clk, rst_n, flat_beat |-> (m_tdata == '0), "flat beat not zero")

    // No result beat follows a clock edge that samples reset low
    `RSI_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind relative_strength_index_core rsi_checker u_rsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for relative_strength_index_core. A price tracker
// keeps its own window of differences and gain/loss sums, works out the RSI
// for each price beat taken by the core that completes the window, and compares each RSI beat in
// order. Directed price extremes and flat windows come first, then random
// price series over several window sizes and handshake idle patterns.
// ---------------------------------------------------------------------------
module testbench;
    import rsi_pkg::*;

    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BEATS   = 160;

    // Expected RSI beat
    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             flat;
    } rsi_beat_t;

    // Price tracker: window of differences, sums and the queue of RSI beats due
    class rsi_tracker;
        logic [PERIOD_W-1:0]   period_reg = PERIOD_RESET;
        logic [DIFF_W-1:0]     diff_hist [MAX_PERIOD];
        logic [SUM_W-1:0]      up_sum   = '0;
        logic [SUM_W-1:0]      down_sum = '0;
        logic [PRICE_BITS-1:0] prev_price = '0;
        int unsigned           n_seen = 0;
        int unsigned           slot = 0;
        rsi_beat_t             rsi_due [$];
        int unsigned           errors = 0;

        function void set_period(logic [PERIOD_W-1:0] value);
            period_reg = value;
        endfunction

        // Price beat taken by the core
        function void take_price(logic [PRICE_BITS-1:0] price, logic restart);
            int unsigned           win;
            logic [DIFF_W-1:0]     old;
            logic [PRICE_BITS-1:0] mag;
            logic [TOT_W-1:0]      total;
            logic [63:0]           scaled;
            rsi_beat_t             beat;
            win = (period_reg == 0) ? 1 :
                  (period_reg > MAX_PERIOD) ? MAX_PERIOD : period_reg;
            // series start: clear history, no result
            if (restart || n_seen == 0)
            begin
                up_sum     = '0;
                down_sum   = '0;
                n_seen     = 1;
                slot       = 0;
                prev_price = price;
                return;
            end
            // drop the difference leaving the window
            if (n_seen > win)
            begin
                old = diff_hist[slot];
                if (old[PRICE_BITS])
                    down_sum = down_sum - SUM_W'(old[PRICE_BITS-1:0]);
                else
                    up_sum = up_sum - SUM_W'(old[PRICE_BITS-1:0]);
            end
            if (price >= prev_price)
            begin
                mag = price - prev_price;
                up_sum = up_sum + SUM_W'(mag);
                diff_hist[slot] = {1'b0, mag};
            end
            else
            begin
                mag = prev_price - price;
                down_sum = down_sum + SUM_W'(mag);
                diff_hist[slot] = {1'b1, mag};
            end
            prev_price = price;
            slot = slot + 1;
            if (slot >= win)
                slot = 0;
            if (n_seen < win + 1)
                n_seen++;
            // count shrinks with a smaller window
            if (n_seen > win + 1)
                n_seen = win + 1;
            // warm-up
            if (n_seen < win + 1)
                return;
            total = TOT_W'(up_sum) + TOT_W'(down_sum);
            if (total == 0)
            begin
                beat.rsi  = '0;
                beat.flat = 1'b1;
            end
            else
            begin
                scaled = (64'(up_sum) * 64'(SCALE)) / 64'(total);
                if (scaled > 64'(SCALE))
                    scaled = 64'(SCALE);
                beat.rsi  = scaled[RSI_W-1:0];
                beat.flat = 1'b0;
            end
            rsi_due.push_back(beat);
        endfunction

        // RSI beat from the core
        function void check_beat(logic [15:0] tdata, logic [0:0] tuser);
            rsi_beat_t want;
            if (rsi_due.size() == 0)
            begin
                $display("%0t: unexpected RSI beat, rsi %0d flat %0b",
                         $time, tdata[RSI_W-1:0], tuser[0]);
                errors++;
                return;
            end
            want = rsi_due.pop_front();
            if (tdata[RSI_W-1:0] !== want.rsi)
            begin
                $display("%0t: rsi mismatch, expected %0d, actual %0d",
                         $time, want.rsi, tdata[RSI_W-1:0]);
                errors++;
            end
            if (tuser[0] !== want.flat)
            begin
                $display("%0t: flat mismatch, expected %0b, actual %0b",
                         $time, want.flat, tuser[0]);
                errors++;
            end
            if (tdata[15] !== 1'b0)
            begin
                $display("%0t: tdata pad bit, expected 0, actual %b", $time, tdata[15]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PRICE_BITS-1:0] s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rsi_tracker  tracker = new();
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    relative_strength_index_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Master side: check RSI beats, random stalls
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_beat(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[relative_strength_index_core] ERROR");
                $finish;
            end
        end
    end

    // One price beat, with a random idle gap ahead of it
    task automatic send_price(input logic [PRICE_BITS-1:0] price, input logic restart);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= price;
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_price(price, restart);
    endtask

    // Hold the sender until every RSI beat due has come
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.rsi_due.size() != 0)
            @(posedge clk);
    endtask

    // Full drain before a register write: warm-up beats may still be in flight
    task automatic drain();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write of the period register
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({REG_PERIOD, 2'b00});
        pwdata  <= CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_period(value);
    endtask

    // Random price series: mostly full windows, some short or broken ones
    task automatic random_series(input int unsigned n_beats, input int unsigned win);
        int unsigned           sent;
        int unsigned           len;
        int unsigned           shape;
        int unsigned           style;
        int unsigned           k;
        int unsigned           step;
        logic [PRICE_BITS-1:0] px;
        logic                  rs;
        logic                  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_beats)
        begin
            shape = $urandom_range(9);
            if (shape < 8)
                len = win + 1 + $urandom_range(0, 2 * win + 8);
            else
                len = $urandom_range(1, win + 1);
            style = $urandom_range(3);
            px = $urandom;
            for (k = 0; k < len && sent < n_beats; k++)
            begin
                rs = (k == 0);
                if (shape == 9 && $urandom_range(3) == 0)
                    rs = 1'($urandom_range(1));
                case (style)
                    0:
                    begin
                        step = $urandom_range(0, 1000);
                        if ($urandom_range(1))
                            px = px + step;
                        else
                            px = px - step;
                    end
                    1: px = $urandom;
                    2: if ($urandom_range(7) == 0) px = px + $urandom_range(0, 3) - 1;
                    default: px = $urandom_range(1) ? '1 : '0;
                endcase
                send_price(px, rs);
                sent++;
                // sender holds off once per phase until the core has caught up
                if (!paused && sent >= n_beats / 2)
                begin
                    paused = 1'b1;
                    wait_results();
                end
            end
        end
    endtask

    // Stimulus
    initial
    begin
        logic [PERIOD_W-1:0] plan [8];
        int unsigned         i;
        int unsigned         win;

        plan[0] = 7'd127;
        plan[1] = 7'd1;
        plan[2] = 7'd64;
        plan[3] = 7'd2;
        plan[4] = 7'd0;
        plan[5] = 7'($urandom_range(3, 40));
        plan[6] = 7'($urandom_range(3, 40));
        plan[7] = PERIOD_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset period: first beat starts a series without restart, then
        // differences of full scale in both directions
        send_price('0, 1'b0);
        for (i = 1; i <= 15; i++)
            send_price((i % 2) ? '1 : '0, 1'b0);
        drain();

        // Period 0 acts as 1: flat windows, all gain, all loss
        write_period(7'd0);
        send_price(32'd5, 1'b1);
        send_price(32'd5, 1'b0);
        send_price(32'd5, 1'b0);
        send_price(32'd6, 1'b0);
        send_price(32'd0, 1'b0);
        send_price(32'd7, 1'b0);
        drain();

        // Random phases over window sizes and idle patterns
        for (i = 0; i < 8; i++)
        begin
            write_period(plan[i]);
            case (i % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            win = (plan[i] == 0) ? 1 : (plan[i] > MAX_PERIOD) ? MAX_PERIOD : plan[i];
            random_series(RANDOM_BEATS, win);
            drain();
        end

        if (tracker.errors == 0)
            $display("[relative_strength_index_core] OK");
        else
            $display("[relative_strength_index_core] ERROR");
        $finish;
    end

endmodule
